// ===== hdl/c8x_pkg.sv =====
// Shared types and constants for the CHIP-8 execute unit.
`timescale 1ns / 1ps
package c8x_pkg;
    localparam int MEM_BYTES   = 4096;
    localparam int STACK_DEPTH = 16;
    localparam int SCREEN_W    = 64;
    localparam int SCREEN_H    = 32;
    localparam int MEM_AW      = 12;
    localparam int ROW_AW      = 5;
    localparam logic [11:0] PC_RESET = 12'h200;

    localparam logic [1:0] FUNC_EXEC = 2'd0;
    localparam logic [1:0] FUNC_MEMW = 2'd1;
    localparam logic [1:0] FUNC_ROWR = 2'd2;
    localparam logic [1:0] FUNC_MEMR = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] opcode;
        logic [11:0] address;
        logic [7:0]  write_data;
        logic [15:0] keys;
        logic [7:0]  delay_now;
        logic [7:0]  random_byte;
    } t_in_word;

    typedef struct packed {
        logic [11:0] next_pc;
        logic [63:0] read_data;
        logic        screen_update;
        logic        unknown_opcode;
        logic        delay_write;
        logic        sound_write;
        logic [7:0]  timer_value;
        logic        waiting_for_key;
    } t_out_word;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,      // capture the word, reg reads, exec advances pc
        OP_SIMPLE,     // opcode effects applied in the decode state
        OP_MEM_RD,     // issue memory read at address or I+cnt
        OP_MEM_WR,     // write memory byte (func 1)
        OP_ROW_RD,     // issue frame row read
        OP_REG_TO_MEM, // Fx55 step
        OP_MEM_TO_REG, // Fx65 step
        OP_BCD_WR,     // Fx33 step
        OP_SPR_ROW,    // draw: read frame row (sprite byte in hand)
        OP_SPR_WR,     // draw: xor and write frame row
        OP_CLR_ROW,    // clear one frame row
        OP_FINISH      // finalize index, flags, pc and read data
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [4:0] cnt;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  major;
        logic [7:0]  nn;
        logic [3:0]  x;
        logic [3:0]  n;
        logic [4:0]  yp;
    } t_dp_status;

    function automatic logic [7:0] mod10(input logic [7:0] v);
        logic [7:0] q;
        q = 8'((16'(v) * 16'd205) >> 11);
        return 8'(v - 8'(q * 8'd10));
    endfunction

    function automatic logic [7:0] div10(input logic [7:0] v);
        return 8'((16'(v) * 16'd205) >> 11);
    endfunction
endpackage

// ===== hdl/c8x_datapath.sv =====
// Datapath: registers, stack, memory, frame buffer and opcode effects.
`timescale 1ns / 1ps
module c8x_datapath
    import c8x_pkg::*;
#(
    parameter int STACK_DEPTH_P = STACK_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_word   i_word,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output t_out_word  o_result
);
    localparam int SPW = $clog2(STACK_DEPTH_P);

    logic [7:0]  r_mem [MEM_BYTES];
    logic [63:0] r_fb  [SCREEN_H];
    logic [11:0] r_stack [STACK_DEPTH_P];
    logic [7:0]  r_v [16];
    logic [11:0] r_pc;
    logic [15:0] r_i;
    logic [SPW-1:0] r_sp;
    t_in_word    r_in;
    logic [7:0]  r_mem_q;
    logic [63:0] r_row_q;
    logic        r_hit;
    t_out_word   r_res;

    logic [3:0]  x, y;
    logic [7:0]  nn, vx, vy;
    logic [11:0] nnn, pc2;
    logic [11:0] ia;
    logic [5:0]  xp;
    logic [4:0]  row;
    logic [63:0] bits;
    logic [8:0]  sum;
    logic        down;
    logic [4:0]  keyi;
    logic [7:0]  rmod;
    logic [SPW-1:0] sp_inc, sp_dec;

    assign x   = r_in.opcode[11:8];
    assign y   = r_in.opcode[7:4];
    assign nn  = r_in.opcode[7:0];
    assign nnn = r_in.opcode[11:0];
    assign vx  = r_v[x];
    assign vy  = r_v[y];
    assign pc2 = r_pc + 12'd2;
    assign ia  = r_i[11:0] + 12'(i_cmd.cnt);
    assign xp  = vx[5:0];
    assign row = o_status.yp + i_cmd.cnt;
    assign bits = ({r_mem_q, 56'd0}) >> xp;
    assign sum = {1'b0, vx} + {1'b0, vy};
    assign down = (vx < 8'd16) && r_in.keys[vx[3:0]];
    assign rmod = (r_in.random_byte == 8'hFF) ? 8'd0 : r_in.random_byte;
    // stack pointer wraps at the stack depth
    assign sp_inc = (r_sp == SPW'(STACK_DEPTH_P - 1)) ? '0 : r_sp + 1'b1;
    assign sp_dec = (r_sp == '0) ? SPW'(STACK_DEPTH_P - 1) : r_sp - 1'b1;

    always_comb begin
        keyi = 5'd16;
        for (int k = 15; k >= 0; k--) begin
            if (r_in.keys[k]) keyi = 5'(k);
        end
    end

    assign o_status.func  = r_in.func;
    assign o_status.major = r_in.opcode[15:12];
    assign o_status.nn    = nn;
    assign o_status.x     = x;
    assign o_status.n     = r_in.opcode[3:0];
    assign o_status.yp    = vy[4:0];
    assign o_result       = r_res;

    // memories
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_MEM_WR:     r_mem[r_in.address] <= r_in.write_data;
            OP_REG_TO_MEM: r_mem[ia] <= r_v[i_cmd.cnt[3:0]];
            OP_BCD_WR: begin
                case (i_cmd.cnt)
                    5'd0:    r_mem[ia] <= div10(div10(vx));
                    5'd1:    r_mem[ia] <= mod10(div10(vx));
                    default: r_mem[ia] <= mod10(vx);
                endcase
            end
            default: ;
        endcase
        r_mem_q <= r_mem[(i_cmd.op == OP_MEM_RD && r_in.func == FUNC_MEMR) ?
                         r_in.address : ia];
        r_row_q <= r_fb[(i_cmd.op == OP_ROW_RD) ? r_in.address[ROW_AW-1:0] : row];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SCREEN_H; k++) r_fb[k] <= '0;
        end else if (i_cmd.op == OP_CLR_ROW) begin
            r_fb[i_cmd.cnt] <= '0;
        end else if (i_cmd.op == OP_SPR_WR) begin
            r_fb[row] <= r_row_q ^ bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_SIMPLE && r_in.opcode[15:12] == 4'h2)
            r_stack[r_sp] <= r_pc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= PC_RESET;
            r_i   <= '0;
            r_sp  <= '0;
            r_hit <= 1'b0;
            for (int k = 0; k < 16; k++) r_v[k] <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_LATCH: begin
                    r_in  <= i_word;
                    r_res <= '0;
                    r_hit <= 1'b0;
                    if (i_word.func == FUNC_EXEC) r_pc <= r_pc + 12'd2;
                end
                OP_SIMPLE: begin
                    unique case (r_in.opcode[15:12])
                        4'h0: begin
                            if (nn == 8'hE0) r_res.screen_update <= 1'b1;
                            else if (nn == 8'hEE) begin
                                r_sp <= sp_dec;
                                r_pc <= r_stack[sp_dec];
                            end else r_res.unknown_opcode <= 1'b1;
                        end
                        4'h1: r_pc <= nnn;
                        4'h2: begin r_sp <= sp_inc; r_pc <= nnn; end
                        4'h3: if (vx == nn) r_pc <= pc2;
                        4'h4: if (vx != nn) r_pc <= pc2;
                        4'h5: if (vx == vy) r_pc <= pc2;
                        4'h6: r_v[x] <= nn;
                        4'h7: r_v[x] <= vx + nn;
                        4'h8: begin
                            case (r_in.opcode[3:0])
                                4'h0: r_v[x] <= vy;
                                4'h1: r_v[x] <= vx | vy;
                                4'h2: r_v[x] <= vx & vy;
                                4'h3: r_v[x] <= vx ^ vy;
                                4'h4: begin
                                    r_v[x] <= sum[7:0]; r_v[15] <= {7'd0, sum[8]};
                                end
                                4'h5: begin
                                    r_v[x] <= vx - vy; r_v[15] <= {7'd0, vx >= vy};
                                end
                                4'h6: begin
                                    r_v[x] <= vx >> 1; r_v[15] <= {7'd0, vx[0]};
                                end
                                4'h7: begin
                                    r_v[x] <= vy - vx; r_v[15] <= {7'd0, vy >= vx};
                                end
                                4'hE: begin
                                    r_v[x] <= vx << 1; r_v[15] <= {7'd0, vx[7]};
                                end
                                default: r_res.unknown_opcode <= 1'b1;
                            endcase
                        end
                        4'h9: if (vx != vy) r_pc <= pc2;
                        4'hA: r_i <= {4'd0, nnn};
                        4'hB: r_pc <= nnn + {4'd0, r_v[0]};
                        4'hC: r_v[x] <= rmod & nn;
                        4'hD: r_res.screen_update <= 1'b1;
                        4'hE: begin
                            if (nn == 8'h9E) begin
                                if (down) r_pc <= pc2;
                            end else if (nn == 8'hA1) begin
                                if (!down) r_pc <= pc2;
                            end else r_res.unknown_opcode <= 1'b1;
                        end
                        default: begin
                            case (nn)
                                8'h07: r_v[x] <= r_in.delay_now;
                                8'h0A: begin
                                    if (keyi[4]) begin
                                        r_pc <= r_pc - 12'd2;
                                        r_res.waiting_for_key <= 1'b1;
                                    end else r_v[x] <= {4'd0, keyi[3:0]};
                                end
                                8'h15: begin
                                    r_res.delay_write <= 1'b1; r_res.timer_value <= vx;
                                end
                                8'h18: begin
                                    r_res.sound_write <= 1'b1; r_res.timer_value <= vx;
                                end
                                8'h1E: r_i <= r_i + {8'd0, vx};
                                8'h29: r_i <= 16'({vx, 2'b00}) + {8'd0, vx};
                                8'h33, 8'h55, 8'h65: ;
                                default: r_res.unknown_opcode <= 1'b1;
                            endcase
                        end
                    endcase
                end
                OP_MEM_TO_REG: r_v[i_cmd.cnt[3:0]] <= r_mem_q;
                OP_SPR_WR: if ((r_row_q & bits) != '0) r_hit <= 1'b1;
                OP_FINISH: begin
                    r_res.next_pc <= r_pc;
                    if (r_in.func == FUNC_MEMR) r_res.read_data <= {56'd0, r_mem_q};
                    if (r_in.func == FUNC_ROWR && r_in.address < 12'(SCREEN_H))
                        r_res.read_data <= r_row_q;
                    if (r_in.func == FUNC_EXEC && r_in.opcode[15:12] == 4'hF &&
                        (nn == 8'h55 || nn == 8'h65))
                        r_i <= r_i + 16'(x) + 16'd1;
                    if (r_in.func == FUNC_EXEC && r_in.opcode[15:12] == 4'hD)
                        r_v[15] <= {7'd0, r_hit};
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== hdl/c8x_control.sv =====
// Sequencer that steps the datapath through each word.
`timescale 1ns / 1ps
module c8x_control
    import c8x_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_valid,
    input  logic       i_stall
);
    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_MEMRD, S_ROWRD, S_CLR, S_BCD, S_STORE,
        S_LOADRD, S_LOAD, S_SPRD, S_SPROW, S_SPWR, S_FIN, S_OUT
    } t_state;

    t_state     r_state;
    logic [4:0] r_cnt;
    logic       r_valid;
    logic       last_row;

    assign o_valid = r_valid;
    assign o_stall = (r_state != S_IDLE);
    assign last_row = (r_cnt + 5'd1 >= 5'(i_status.n)) ||
                      (6'(i_status.yp) + 6'(r_cnt) + 6'd1 >= 6'(SCREEN_H));

    always_comb begin
        o_cmd.cnt = r_cnt;
        unique case (r_state)
            S_IDLE:   o_cmd.op = i_valid ? OP_LATCH : OP_NONE;
            S_DECODE: o_cmd.op = (i_status.func == FUNC_EXEC) ? OP_SIMPLE :
                                 (i_status.func == FUNC_MEMW) ? OP_MEM_WR :
                                 (i_status.func == FUNC_ROWR) ? OP_ROW_RD : OP_MEM_RD;
            S_MEMRD:  o_cmd.op = OP_MEM_RD;
            S_ROWRD:  o_cmd.op = OP_ROW_RD;
            S_CLR:    o_cmd.op = OP_CLR_ROW;
            S_BCD:    o_cmd.op = OP_BCD_WR;
            S_STORE:  o_cmd.op = OP_REG_TO_MEM;
            S_LOADRD: o_cmd.op = OP_MEM_RD;
            S_LOAD:   o_cmd.op = OP_MEM_TO_REG;
            S_SPRD:   o_cmd.op = OP_MEM_RD;
            S_SPROW:  o_cmd.op = OP_SPR_ROW;
            S_SPWR:   o_cmd.op = OP_SPR_WR;
            S_FIN:    o_cmd.op = OP_FINISH;
            default:  o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) r_state <= S_DECODE;
                S_DECODE: begin
                    r_cnt <= '0;
                    if (i_status.func == FUNC_EXEC) begin
                        if (i_status.major == 4'h0 && i_status.nn == 8'hE0)
                            r_state <= S_CLR;
                        else if (i_status.major == 4'hD && i_status.n != 4'd0)
                            r_state <= S_SPRD;
                        else if (i_status.major == 4'hF && i_status.nn == 8'h33)
                            r_state <= S_BCD;
                        else if (i_status.major == 4'hF && i_status.nn == 8'h55)
                            r_state <= S_STORE;
                        else if (i_status.major == 4'hF && i_status.nn == 8'h65)
                            r_state <= S_LOADRD;
                        else r_state <= S_FIN;
                    end else if (i_status.func == FUNC_MEMR) r_state <= S_MEMRD;
                    else if (i_status.func == FUNC_ROWR) r_state <= S_ROWRD;
                    else r_state <= S_FIN;
                end
                S_MEMRD: r_state <= S_FIN;
                S_ROWRD: r_state <= S_FIN;
                S_CLR: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(SCREEN_H - 1)) r_state <= S_FIN;
                end
                S_BCD: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd2) r_state <= S_FIN;
                end
                S_STORE: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt[3:0] == i_status.x) r_state <= S_FIN;
                end
                S_LOADRD: r_state <= S_LOAD;
                S_LOAD: begin
                    r_cnt <= r_cnt + 5'd1;
                    r_state <= (r_cnt[3:0] == i_status.x) ? S_FIN : S_LOADRD;
                end
                S_SPRD:  r_state <= S_SPROW;
                S_SPROW: r_state <= S_SPWR;
                S_SPWR: begin
                    r_cnt <= r_cnt + 5'd1;
                    r_state <= last_row ? S_FIN : S_SPRD;
                end
                S_FIN: begin
                    r_state <= S_OUT;
                    r_valid <= 1'b1;
                end
                S_OUT: if (!i_stall) begin
                    r_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> r_valid) else $error("result dropped");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> o_stall) else $error("accepting while result pending");
    a_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> r_valid) else $error("finish without result");
endmodule

// ===== hdl/chip8_instruction_execute_unit.sv =====
// Top level of the CHIP-8 instruction execute unit.
`timescale 1ns / 1ps
// One word at a time: each word passes the decode, finish and output states,
// with a memory or row read state before finish for reads; 00E0 clears one
// frame row a cycle; Dxyn reads each sprite byte, then its frame row, then
// writes it back, through the single memory and frame ports; Fx33, Fx55 and
// Fx65 step bytewise. Input stall stays high until the result word has been taken.
module chip8_instruction_execute_unit
    import c8x_pkg::*;
#(
    parameter int STACK_DEPTH_P = STACK_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word
);
    t_dp_cmd    cmd;
    t_dp_status status;

    c8x_control u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_status(status), .o_cmd(cmd), .o_valid, .i_stall
    );

    c8x_datapath #(.STACK_DEPTH_P(STACK_DEPTH_P)) u_dp (
        .i_clk, .i_rst_n, .i_word, .i_cmd(cmd), .o_status(status), .o_result(o_word)
    );
endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the CHIP-8 instruction execute unit.
`timescale 1ns / 1ps
module tb_top;
    import c8x_pkg::*;

    localparam int N_RANDOM   = 1200;
    localparam int FILL_BYTES = 256;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_AT    = 600;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_AT   = 800;

    localparam logic [7:0] F_CODES [9] = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E,
                                           8'h29, 8'h33, 8'h55, 8'h65};
    localparam logic [3:0] ALU_CODES [9] = '{4'h0, 4'h1, 4'h2, 4'h3, 4'h4,
                                             4'h5, 4'h6, 4'h7, 4'hE};

    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word res;
    } t_vector;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_word  i_word = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_word o_word;

    chip8_instruction_execute_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

    always #1 i_clk = ~i_clk;

    // machine state mirror
    logic [11:0] pc_m;
    logic [7:0]  vreg [16];
    logic [15:0] idx_m;
    int          sp_m;
    logic [11:0] stk_m [STACK_DEPTH];
    bit          stk_ok [STACK_DEPTH];
    logic [7:0]  mem_m [MEM_BYTES];
    bit          mem_ok [MEM_BYTES];
    logic [63:0] fb_m [SCREEN_H];

    t_out_word   pending_q [$];
    t_vector     directed [$];
    int          n_err = 0;
    int          n_sent = 0;
    int          burst_left = 0;

    function automatic logic [11:0] maddr(input int k);
        return 12'((32'(idx_m) + k) & (MEM_BYTES - 1));
    endfunction

    function automatic t_out_word execute_word(input t_in_word w);
        t_out_word   r;
        logic [3:0]  x, y, n;
        logic [7:0]  nn, vx, vy;
        logic [11:0] nnn;
        logic [8:0]  sum;
        logic [63:0] bits;
        bit          hit, down;
        int          row, k;
        r = '0;
        if (w.func == FUNC_MEMW) begin
            mem_m[w.address] = w.write_data;
            mem_ok[w.address] = 1'b1;
        end else if (w.func == FUNC_ROWR) begin
            if (w.address < SCREEN_H) r.read_data = fb_m[w.address];
        end else if (w.func == FUNC_MEMR) begin
            r.read_data = 64'(mem_m[w.address]);
        end else begin
            x = w.opcode[11:8]; y = w.opcode[7:4]; n = w.opcode[3:0];
            nn = w.opcode[7:0]; nnn = w.opcode[11:0];
            vx = vreg[x]; vy = vreg[y];
            pc_m = pc_m + 12'd2;
            case (w.opcode[15:12])
                4'h0: begin
                    if (nn == 8'hE0) begin
                        for (k = 0; k < SCREEN_H; k++) fb_m[k] = '0;
                        r.screen_update = 1'b1;
                    end else if (nn == 8'hEE) begin
                        sp_m = (sp_m + STACK_DEPTH - 1) % STACK_DEPTH;
                        pc_m = stk_m[sp_m];
                    end else begin
                        r.unknown_opcode = 1'b1;
                    end
                end
                4'h1: pc_m = nnn;
                4'h2: begin
                    stk_m[sp_m] = pc_m;
                    stk_ok[sp_m] = 1'b1;
                    sp_m = (sp_m + 1) % STACK_DEPTH;
                    pc_m = nnn;
                end
                4'h3: if (vx == nn) pc_m = pc_m + 12'd2;
                4'h4: if (vx != nn) pc_m = pc_m + 12'd2;
                4'h5: if (vx == vy) pc_m = pc_m + 12'd2;
                4'h6: vreg[x] = nn;
                4'h7: vreg[x] = vx + nn;
                4'h8: begin
                    case (n)
                        4'h0: vreg[x] = vy;
                        4'h1: vreg[x] = vx | vy;
                        4'h2: vreg[x] = vx & vy;
                        4'h3: vreg[x] = vx ^ vy;
                        4'h4: begin
                            sum = 9'(vx) + 9'(vy);
                            vreg[x] = sum[7:0]; vreg[15] = 8'(sum[8]);
                        end
                        4'h5: begin vreg[x] = vx - vy; vreg[15] = 8'(vx >= vy); end
                        4'h6: begin vreg[x] = vx >> 1; vreg[15] = 8'(vx[0]); end
                        4'h7: begin vreg[x] = vy - vx; vreg[15] = 8'(vy >= vx); end
                        4'hE: begin vreg[x] = vx << 1; vreg[15] = 8'(vx[7]); end
                        default: r.unknown_opcode = 1'b1;
                    endcase
                end
                4'h9: if (vx != vy) pc_m = pc_m + 12'd2;
                4'hA: idx_m = 16'(nnn);
                4'hB: pc_m = 12'(vreg[0]) + nnn;
                4'hC: vreg[x] = 8'(32'(w.random_byte) % 255) & nn;
                4'hD: begin
                    hit = 1'b0;
                    for (k = 0; k < n; k++) begin
                        row = (vy % SCREEN_H) + k;
                        if (row >= SCREEN_H) break;
                        bits = {mem_m[maddr(k)], 56'd0} >> (vx % SCREEN_W);
                        if ((fb_m[row] & bits) != 0) hit = 1'b1;
                        fb_m[row] = fb_m[row] ^ bits;
                    end
                    vreg[15] = 8'(hit);
                    r.screen_update = 1'b1;
                end
                4'hE: begin
                    down = (vx < 16) && w.keys[vx[3:0]];
                    if (nn == 8'h9E) begin
                        if (down) pc_m = pc_m + 12'd2;
                    end else if (nn == 8'hA1) begin
                        if (!down) pc_m = pc_m + 12'd2;
                    end else begin
                        r.unknown_opcode = 1'b1;
                    end
                end
                default: begin
                    case (nn)
                        8'h07: vreg[x] = w.delay_now;
                        8'h0A: begin
                            if (w.keys == 0) begin
                                pc_m = pc_m - 12'd2;
                                r.waiting_for_key = 1'b1;
                            end else begin
                                for (k = 15; k >= 0; k--)
                                    if (w.keys[k]) vreg[x] = 8'(k);
                            end
                        end
                        8'h15: begin r.delay_write = 1'b1; r.timer_value = vx; end
                        8'h18: begin r.sound_write = 1'b1; r.timer_value = vx; end
                        8'h1E: idx_m = idx_m + 16'(vx);
                        8'h29: idx_m = 16'(vx) * 16'd5;
                        8'h33: begin
                            mem_m[maddr(0)] = vx / 100;
                            mem_m[maddr(1)] = (vx / 10) % 10;
                            mem_m[maddr(2)] = vx % 10;
                            for (k = 0; k < 3; k++) mem_ok[maddr(k)] = 1'b1;
                        end
                        8'h55: begin
                            for (k = 0; k <= x; k++) begin
                                mem_m[maddr(k)] = vreg[k];
                                mem_ok[maddr(k)] = 1'b1;
                            end
                            idx_m = idx_m + 16'(x) + 16'd1;
                        end
                        8'h65: begin
                            for (k = 0; k <= x; k++) vreg[k] = mem_m[maddr(k)];
                            idx_m = idx_m + 16'(x) + 16'd1;
                        end
                        default: r.unknown_opcode = 1'b1;
                    endcase
                end
            endcase
        end
        r.next_pc = pc_m;
        return r;
    endfunction

    function automatic t_in_word mk(input logic [1:0] f, input logic [15:0] op,
                                    input logic [11:0] a, input logic [15:0] keys);
        t_in_word w;
        w.func = f; w.opcode = op; w.address = a; w.keys = keys;
        w.write_data = 8'($urandom); w.delay_now = 8'($urandom);
        w.random_byte = 8'hFF;
        return w;
    endfunction

    function automatic t_out_word res(input logic [11:0] pc, input logic unk);
        t_out_word r;
        r = '0; r.next_pc = pc; r.unknown_opcode = unk;
        return r;
    endfunction

    function automatic t_in_word random_word();
        t_in_word    w;
        logic [3:0]  x, y, n;
        logic [7:0]  nn;
        logic [11:0] nnn;
        int          reads, k;
        w = '0;
        w.address = 12'($urandom); w.write_data = 8'($urandom);
        w.delay_now = 8'($urandom); w.random_byte = 8'($urandom);
        x = 4'($urandom); y = 4'($urandom); n = 4'($urandom);
        nn = 8'($urandom); nnn = 12'($urandom);
        w.keys = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
        case ($urandom_range(0, 9))
            0: w.func = FUNC_MEMW;
            1: w.func = FUNC_MEMR;
            2: begin
                w.func = FUNC_ROWR;
                if ($urandom_range(0, 1)) w.address = 12'($urandom_range(0, SCREEN_H - 1));
            end
            default: w.func = FUNC_EXEC;
        endcase
        case ($urandom_range(0, 22))
            0:  w.opcode = ($urandom_range(0, 2) == 0) ? 16'h00E0 : {4'h6, x, nn};
            1:  w.opcode = 16'h00EE;
            2:  w.opcode = {4'h1, nnn};
            3:  w.opcode = {4'h2, nnn};
            4:  w.opcode = {4'h3, x, nn};
            5:  w.opcode = {4'h4, x, nn};
            6:  w.opcode = {4'h5, x, y, n};
            7, 21: w.opcode = {4'h6, x, nn};
            8:  w.opcode = {4'h7, x, nn};
            9, 10, 11: begin
                if ($urandom_range(0, 3) != 0) n = ALU_CODES[$urandom_range(0, 8)];
                w.opcode = {4'h8, x, y, n};
            end
            12: w.opcode = {4'h9, x, y, n};
            13: w.opcode = ($urandom_range(0, 3) != 0) ? {4'hA, 4'h0, nn} : {4'hA, nnn};
            14: w.opcode = {4'hB, nnn};
            15: w.opcode = {4'hC, x, nn};
            16, 17: w.opcode = {4'hD, x, y, n};
            18: w.opcode = {4'hE, x, $urandom_range(0, 1) ? 8'h9E : 8'hA1};
            19, 22: w.opcode = {4'hF, x, F_CODES[$urandom_range(0, 8)]};
            default: w.opcode = 16'($urandom);
        endcase
        if (w.func == FUNC_EXEC) begin
            // steer sprite and block loads away from unwritten bytes
            reads = 0;
            if (w.opcode[15:12] == 4'hD)
                reads = int'(w.opcode[3:0]);
            else if (w.opcode[15:12] == 4'hF && w.opcode[7:0] == 8'h65)
                reads = int'(w.opcode[11:8]) + 1;
            for (k = 0; k < reads; k++)
                if (!mem_ok[maddr(k)]) w.opcode = {4'hA, 4'h0, nn};
            if (w.opcode[15:12] == 4'h0 && w.opcode[7:0] == 8'hEE
                && !stk_ok[(sp_m + STACK_DEPTH - 1) % STACK_DEPTH])
                w.opcode = {4'h2, nnn};
        end else if (w.func == FUNC_MEMR && !mem_ok[w.address]) begin
            w.address = {4'd0, w.address[7:0]};
        end
        return w;
    endfunction

    task automatic send(input t_in_word w, input bit typed, input t_out_word texp);
        t_out_word e;
        int        g;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            g = $urandom_range(0, 6);
            if (g > 0) i_valid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        burst_left--;
        i_word = w;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        e = execute_word(w);
        pending_q.push_back(typed ? texp : e);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
        if (e !== a) begin
            $error("%s: expected %0h, got %0h", name, e, a);
            n_err++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_q.size() == 0) begin
                $error("result word with nothing expected");
                n_err++;
            end else begin
                e = pending_q.pop_front();
                check_field("next_pc", e.next_pc, o_word.next_pc);
                check_field("read_data", e.read_data, o_word.read_data);
                check_field("screen_update", e.screen_update, o_word.screen_update);
                check_field("unknown_opcode", e.unknown_opcode, o_word.unknown_opcode);
                check_field("delay_write", e.delay_write, o_word.delay_write);
                check_field("sound_write", e.sound_write, o_word.sound_write);
                check_field("timer_value", e.timer_value, o_word.timer_value);
                check_field("waiting_for_key", e.waiting_for_key, o_word.waiting_for_key);
            end
        end
    end

    // receiver stall pattern with one long hold-off
    int  hold_left = 0;
    bit  held = 1'b0;
    int  rx_mode = 0;
    int  rx_left = 0;
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!held && n_sent >= HOLD_AT) begin
            held = 1'b1;
            hold_left = HOLD_LEN;
            i_stall <= 1'b1;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            case (rx_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                default: i_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    int idle_cnt = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_vector v;
        int      k;
        pc_m = PC_RESET; idx_m = '0; sp_m = 0;
        for (k = 0; k < 16; k++) vreg[k] = '0;
        for (k = 0; k < STACK_DEPTH; k++) stk_ok[k] = 1'b0;
        for (k = 0; k < MEM_BYTES; k++) mem_ok[k] = 1'b0;
        for (k = 0; k < SCREEN_H; k++) fb_m[k] = '0;

        v.typed = 1'b1;
        v.w = mk(FUNC_ROWR, 16'h0000, 12'd0, 16'd0);       v.res = res(12'h200, 0);
        directed.push_back(v);
        v.w = mk(FUNC_ROWR, 16'hFFFF, 12'hFFF, 16'hFFFF);  v.res = res(12'h200, 0);
        directed.push_back(v);
        v.w = mk(FUNC_EXEC, 16'h0000, 12'd0, 16'd0);       v.res = res(12'h202, 1);
        directed.push_back(v);
        v.w = mk(FUNC_EXEC, 16'h1FFF, 12'd0, 16'd0);       v.res = res(12'hFFF, 0);
        directed.push_back(v);
        v.w = mk(FUNC_EXEC, 16'h3000, 12'd0, 16'd0);       v.res = res(12'h003, 0);
        directed.push_back(v);
        v.w = mk(FUNC_EXEC, 16'h60FF, 12'd0, 16'd0);       v.res = res(12'h005, 0);
        directed.push_back(v);
        v.typed = 1'b0; v.res = '0;
        v.w = mk(FUNC_EXEC, 16'h8004, 12'd0, 16'd0);     directed.push_back(v);
        v.w = mk(FUNC_EXEC, 16'hF015, 12'd0, 16'd0);     directed.push_back(v);
        v.w = mk(FUNC_EXEC, 16'hF118, 12'd0, 16'd0);     directed.push_back(v);
        v.w = mk(FUNC_EXEC, 16'hF20A, 12'd0, 16'd0);     directed.push_back(v);
        v.w = mk(FUNC_EXEC, 16'hF30A, 12'd0, 16'h8000);  directed.push_back(v);
        v.w = mk(FUNC_EXEC, 16'hE39E, 12'd0, 16'h8000);  directed.push_back(v);
        v.w = mk(FUNC_EXEC, 16'h6510, 12'd0, 16'd0);     directed.push_back(v);
        v.w = mk(FUNC_EXEC, 16'hE5A1, 12'd0, 16'hFFFF);  directed.push_back(v);
        v.w = mk(FUNC_EXEC, 16'hAFFE, 12'd0, 16'd0);     directed.push_back(v);
        v.w = mk(FUNC_EXEC, 16'hF033, 12'd0, 16'd0);     directed.push_back(v);
        v.w = mk(FUNC_MEMR, 16'h0000, 12'hFFF, 16'd0);   directed.push_back(v);
        v.w = mk(FUNC_EXEC, 16'hD000, 12'd0, 16'd0);     directed.push_back(v);
        v.w = mk(FUNC_EXEC, 16'h6C3F, 12'd0, 16'd0);     directed.push_back(v);
        v.w = mk(FUNC_EXEC, 16'hDCCF, 12'd0, 16'd0);     directed.push_back(v);
        v.w = mk(FUNC_ROWR, 16'h0000, 12'd31, 16'd0);    directed.push_back(v);
        v.w = mk(FUNC_EXEC, 16'h00E0, 12'd0, 16'd0);     directed.push_back(v);
        v.w = mk(FUNC_EXEC, 16'h2ABC, 12'd0, 16'd0);     directed.push_back(v);
        v.w = mk(FUNC_EXEC, 16'h00EE, 12'd0, 16'd0);     directed.push_back(v);
        v.w = mk(FUNC_EXEC, 16'hFF55, 12'd0, 16'd0);     directed.push_back(v);
        v.w = mk(FUNC_EXEC, 16'hFF65, 12'd0, 16'd0);     directed.push_back(v);
        v.w = mk(FUNC_EXEC, 16'hC0FF, 12'd0, 16'd0);     directed.push_back(v);
        v.w = mk(FUNC_EXEC, 16'h8AB5, 12'd0, 16'd0);     directed.push_back(v);
        v.w = mk(FUNC_EXEC, 16'hBFFF, 12'd0, 16'd0);     directed.push_back(v);

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // fill the low window; later reads are steered to written bytes
        for (k = 0; k < FILL_BYTES; k++)
            send(mk(FUNC_MEMW, 16'($urandom), 12'(k), 16'($urandom)), 1'b0, '0);
        foreach (directed[j]) send(directed[j].w, directed[j].typed, directed[j].res);

        for (k = 0; k < N_RANDOM; k++) begin
            if (k == DRAIN_AT) begin
                i_valid = 1'b0;
                while (pending_q.size() != 0) @(negedge i_clk);
            end
            send(random_word(), 1'b0, '0);
        end
        i_valid = 1'b0;

        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (pending_q.size() != 0) n_err++;
        if (n_err == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
